[rtl/pwfp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pwfp_pkg
// Shared types and constants for the protobuf wire field parser: result
// kinds, wire types, parser phases and the record carried by the result queue.
// ----------------------------------------------------------------------------
package pwfp_pkg;

    localparam int MAX_VARINT_BYTES_DEF = 10;
    localparam int LENGTH_BITS_DEF      = 32;
    localparam int QUEUE_DEPTH_DEF      = 4;

    localparam int FID_W  = 29;
    localparam int IDX_W  = 4;
    localparam int WORD_W = 64;

    typedef enum logic [2:0] {
        KIND_SCALAR   = 3'd0,
        KIND_HEADER   = 3'd1,
        KIND_PAYLOAD  = 3'd2,
        KIND_BAD_WIRE = 3'd3,
        KIND_TRUNC    = 3'd4
    } res_kind_t;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LENGTH  = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    typedef enum logic [2:0] {
        PH_KEY     = 3'd0,
        PH_VARVAL  = 3'd1,
        PH_FIXED   = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    // word holds the value for scalars and headers, the byte for payload items
    typedef struct packed {
        res_kind_t          kind;
        logic [FID_W-1:0]   fid;
        logic [2:0]         wk;
        logic [WORD_W-1:0]  word;
        logic               done;
    } pwfp_rec_t;

endpackage : pwfp_pkg
`default_nettype wire

[rtl/pwfp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pwfp_front
// Byte parser: classifies each accepted byte against the parse phase, updates
// the varint / fixed accumulator and pushes at most one result record.
// ----------------------------------------------------------------------------
module pwfp_front
    import pwfp_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF,
    parameter int LENGTH_BITS      = LENGTH_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_fire,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_message,
    output logic            push,
    output pwfp_rec_t       push_rec
);

    localparam logic [WORD_W-1:0] LEN_MAX   = (64'd1 << LENGTH_BITS) - 64'd1;
    localparam logic [IDX_W-1:0]  IDX_LIMIT = IDX_W'(MAX_VARINT_BYTES);

    typedef enum logic [3:0] {
        ACT_WAIT,
        ACT_SKIP,
        ACT_RESYNC,
        ACT_CLEAR,
        ACT_VINT_MORE,
        ACT_FIX_MORE,
        ACT_KEY_DONE,
        ACT_LEN_START,
        ACT_PAY_MORE,
        ACT_EMIT_DONE,
        ACT_FAIL_TRUNC,
        ACT_FAIL_WIRE
    } act_t;

    phase_t                  phase_reg, phase_next;
    logic                    err_reg, err_next;
    logic [WORD_W-1:0]       acc_reg, acc_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [FID_W-1:0]        fid_reg, fid_next;
    logic [2:0]              wk_reg, wk_next;
    logic [LENGTH_BITS-1:0]  left_reg, left_next;

    act_t                    act;
    logic [IDX_W-1:0]        idx_inc;
    logic [6:0]              vint_shamt;
    logic [WORD_W-1:0]       vint_value;
    logic [WORD_W-1:0]       fix_value;
    logic                    vint_over;
    logic                    fix_last;
    logic [FID_W-1:0]        key_fid;
    logic [2:0]              key_wk;
    logic                    key_bad;
    logic                    len_big;
    logic                    len_zero;
    logic [LENGTH_BITS-1:0]  left_dec;
    logic                    left_last;

    // ------------------------------------------------------------------
    // Byte decode
    // ------------------------------------------------------------------
    assign idx_inc    = idx_reg + IDX_W'(1);
    assign vint_shamt = {3'd0, idx_reg} * 7'd7;
    assign vint_value = acc_reg | ((vint_shamt < 7'd64)
                        ? ({57'd0, data_byte[6:0]} << vint_shamt[5:0]) : '0);
    assign fix_value  = acc_reg | ({56'd0, data_byte} << {idx_reg[2:0], 3'b000});
    assign vint_over  = (idx_inc >= IDX_LIMIT);
    assign fix_last   = (idx_inc >= ((wk_reg == WT_FIXED64) ? IDX_W'(8) : IDX_W'(4)));
    assign key_fid    = vint_value[FID_W+2:3];
    assign key_wk     = vint_value[2:0];
    assign key_bad    = !((key_wk == WT_VARINT) || (key_wk == WT_FIXED64) ||
                          (key_wk == WT_LENGTH) || (key_wk == WT_FIXED32));
    assign len_big    = |(vint_value & ~LEN_MAX);
    assign len_zero   = (vint_value == '0);
    assign left_dec   = (left_reg == '0) ? '0 : left_reg - LENGTH_BITS'(1);
    assign left_last  = (left_dec == '0);

    // Classify the byte
    always_comb
    begin
        act = ACT_WAIT;
        if (byte_fire)
        begin
            if (err_reg)
            begin
                act = end_of_message ? ACT_RESYNC : ACT_SKIP;
            end
            else
            begin
                unique case (phase_reg)
                    PH_KEY, PH_VARVAL, PH_LENGTH:
                    begin
                        if (data_byte[7])
                        begin
                            act = (vint_over || end_of_message) ? ACT_FAIL_TRUNC
                                                                : ACT_VINT_MORE;
                        end
                        else if (phase_reg == PH_KEY)
                        begin
                            if (key_bad)
                                act = ACT_FAIL_WIRE;
                            else if (end_of_message)
                                act = ACT_FAIL_TRUNC;
                            else
                                act = ACT_KEY_DONE;
                        end
                        else if (phase_reg == PH_VARVAL)
                        begin
                            act = ACT_EMIT_DONE;
                        end
                        else if (len_big)
                        begin
                            act = ACT_FAIL_TRUNC;
                        end
                        else if (len_zero)
                        begin
                            act = ACT_EMIT_DONE;
                        end
                        else
                        begin
                            act = end_of_message ? ACT_FAIL_TRUNC : ACT_LEN_START;
                        end
                    end
                    PH_FIXED:
                    begin
                        if (fix_last)
                            act = ACT_EMIT_DONE;
                        else
                            act = end_of_message ? ACT_FAIL_TRUNC : ACT_FIX_MORE;
                    end
                    PH_PAYLOAD:
                    begin
                        if (left_last)
                            act = ACT_EMIT_DONE;
                        else
                            act = end_of_message ? ACT_FAIL_TRUNC : ACT_PAY_MORE;
                    end
                    default:
                    begin
                        act = ACT_CLEAR;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Next phase and error hold
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next = phase_reg;
        err_next   = err_reg;
        unique case (act)
            ACT_WAIT, ACT_SKIP, ACT_VINT_MORE, ACT_FIX_MORE, ACT_PAY_MORE:
            begin
                phase_next = phase_reg;
            end
            ACT_KEY_DONE:
            begin
                case (key_wk) inside
                    WT_VARINT: phase_next = PH_VARVAL;
                    WT_LENGTH: phase_next = PH_LENGTH;
                    default:   phase_next = PH_FIXED;
                endcase
            end
            ACT_LEN_START:
            begin
                phase_next = PH_PAYLOAD;
            end
            ACT_FAIL_TRUNC, ACT_FAIL_WIRE:
            begin
                phase_next = PH_KEY;
                err_next   = !end_of_message;
            end
            ACT_RESYNC:
            begin
                phase_next = PH_KEY;
                err_next   = 1'b0;
            end
            default:
            begin
                phase_next = PH_KEY;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result record
    // ------------------------------------------------------------------
    always_comb
    begin
        push          = 1'b0;
        push_rec.kind = KIND_SCALAR;
        push_rec.fid  = fid_reg;
        push_rec.wk   = WT_LENGTH;
        push_rec.word = '0;
        push_rec.done = end_of_message;
        unique case (act)
            ACT_LEN_START:
            begin
                push          = 1'b1;
                push_rec.kind = KIND_HEADER;
                push_rec.word = vint_value;
                push_rec.done = 1'b0;
            end
            ACT_PAY_MORE:
            begin
                push          = 1'b1;
                push_rec.kind = KIND_PAYLOAD;
                push_rec.word = {56'd0, data_byte};
                push_rec.done = 1'b0;
            end
            ACT_EMIT_DONE:
            begin
                push = 1'b1;
                case (phase_reg)
                    PH_VARVAL:
                    begin
                        push_rec.kind = KIND_SCALAR;
                        push_rec.wk   = WT_VARINT;
                        push_rec.word = vint_value;
                    end
                    PH_FIXED:
                    begin
                        push_rec.kind = KIND_SCALAR;
                        push_rec.wk   = wk_reg;
                        push_rec.word = fix_value;
                    end
                    PH_PAYLOAD:
                    begin
                        push_rec.kind = KIND_PAYLOAD;
                        push_rec.word = {56'd0, data_byte};
                    end
                    default:
                    begin
                        // zero-length header
                        push_rec.kind = KIND_HEADER;
                    end
                endcase
            end
            ACT_FAIL_TRUNC:
            begin
                push          = 1'b1;
                push_rec.kind = KIND_TRUNC;
                push_rec.fid  = '0;
                push_rec.wk   = '0;
            end
            ACT_FAIL_WIRE:
            begin
                push          = 1'b1;
                push_rec.kind = KIND_BAD_WIRE;
                push_rec.fid  = key_fid;
                push_rec.wk   = key_wk;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Accumulator, byte count and held field
    // ------------------------------------------------------------------
    always_comb
    begin
        acc_next  = '0;
        idx_next  = '0;
        fid_next  = fid_reg;
        wk_next   = wk_reg;
        left_next = left_reg;
        case (act)
            ACT_WAIT, ACT_SKIP, ACT_PAY_MORE:
            begin
                acc_next = acc_reg;
                idx_next = idx_reg;
                if (act == ACT_PAY_MORE)
                    left_next = left_dec;
            end
            ACT_VINT_MORE:
            begin
                acc_next = vint_value;
                idx_next = idx_inc;
            end
            ACT_FIX_MORE:
            begin
                acc_next = fix_value;
                idx_next = idx_inc;
            end
            ACT_KEY_DONE:
            begin
                fid_next = key_fid;
                wk_next  = key_wk;
            end
            ACT_LEN_START:
            begin
                left_next = vint_value[LENGTH_BITS-1:0];
            end
            default:
            begin
                // clear the parse
                acc_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KEY;
            err_reg   <= 1'b0;
            acc_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            err_reg   <= err_next;
            acc_reg   <= acc_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fid_reg  <= fid_next;
        wk_reg   <= wk_next;
        left_reg <= left_next;
    end

endmodule : pwfp_front
`default_nettype wire

[rtl/pwfp_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pwfp_queue
// Short result queue in flip-flops between the parser and the output stage.
// ----------------------------------------------------------------------------
module pwfp_queue
    import pwfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire pwfp_rec_t push_rec,
    output logic           full,
    input  wire logic      pop,
    output pwfp_rec_t      pop_rec,
    output logic           empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    pwfp_rec_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_rec = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

endmodule : pwfp_queue
`default_nettype wire

[rtl/pwfp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pwfp_back
// Output stage: pops a queued record, splits its shared word into value and
// payload byte, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module pwfp_back
    import pwfp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pwfp_rec_t          pop_rec,
    input  wire logic               empty,
    output logic                    pop,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [2:0]              result_kind,
    output logic [FID_W-1:0]        field_id,
    output logic [2:0]              wire_kind,
    output logic [WORD_W-1:0]       field_value,
    output logic [7:0]              payload_data,
    output logic                    message_done
);

    logic               valid_reg, valid_next;
    logic [2:0]         kind_reg, kind_next;
    logic [FID_W-1:0]   fid_reg, fid_next;
    logic [2:0]         wk_reg, wk_next;
    logic [WORD_W-1:0]  value_reg, value_next;
    logic [7:0]         data_reg, data_next;
    logic               done_reg, done_next;

    // load whenever the output register is empty or being taken
    assign pop        = !empty && (!valid_reg || !result_stall);
    assign valid_next = pop || (valid_reg && result_stall);

    always_comb
    begin
        kind_next  = pop_rec.kind;
        fid_next   = pop_rec.fid;
        wk_next    = pop_rec.wk;
        done_next  = pop_rec.done;
        value_next = '0;
        data_next  = '0;
        case (pop_rec.kind)
            KIND_SCALAR, KIND_HEADER: value_next = pop_rec.word;
            KIND_PAYLOAD:             data_next  = pop_rec.word[7:0];
            default:                  value_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= kind_next;
            fid_reg   <= fid_next;
            wk_reg    <= wk_next;
            value_reg <= value_next;
            data_reg  <= data_next;
            done_reg  <= done_next;
        end
    end

    assign result_valid = valid_reg;
    assign result_kind  = kind_reg;
    assign field_id     = fid_reg;
    assign wire_kind    = wk_reg;
    assign field_value  = value_reg;
    assign payload_data = data_reg;
    assign message_done = done_reg;

endmodule : pwfp_back
`default_nettype wire

[rtl/protobuf_wire_field_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// protobuf_wire_field_parser
// Protobuf wire-format field parser fed one message byte per item; gives one
// result item per scalar, length header, payload byte or error.
//
//   channel   valid          stall          payload
//   bytes     byte_valid     byte_stall     data_byte, end_of_message
//   results   result_valid   result_stall   result_kind .. message_done
//
// One byte is taken every cycle while the result queue is not full; each
// byte is handled in the cycle it is accepted by the parser, whose per-byte
// step is a shift-and-or into the 64-bit accumulator. A result passes through
// the result queue and the output register before it reaches the ports.
// byte_stall rises only when the QUEUE_DEPTH-entry result queue is full, so
// a stalled result side backs up into the byte side.
// Reset clears the parse state, the queue and the output valid at once.
// ----------------------------------------------------------------------------
module protobuf_wire_field_parser
    import pwfp_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF,
    parameter int LENGTH_BITS      = LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_stall,
    input  wire logic [7:0]         data_byte,
    input  wire logic               end_of_message,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [2:0]              result_kind,
    output logic [FID_W-1:0]        field_id,
    output logic [2:0]              wire_kind,
    output logic [WORD_W-1:0]       field_value,
    output logic [7:0]              payload_data,
    output logic                    message_done
);

    logic       byte_fire;
    logic       push;
    pwfp_rec_t  push_rec;
    logic       full;
    logic       pop;
    pwfp_rec_t  pop_rec;
    logic       empty;

    assign byte_stall = full;
    assign byte_fire  = byte_valid && !full;

    pwfp_front #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES),
        .LENGTH_BITS      (LENGTH_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_fire      (byte_fire),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .push           (push),
        .push_rec       (push_rec)
    );

    pwfp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (full),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .empty    (empty)
    );

    pwfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_rec      (pop_rec),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (result_kind),
        .field_id     (field_id),
        .wire_kind    (wire_kind),
        .field_value  (field_value),
        .payload_data (payload_data),
        .message_done (message_done)
    );

endmodule : protobuf_wire_field_parser
`default_nettype wire

[rtl/pwfp_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pwfp_checker
// Port-level checks on the result channel of the field parser.
// ----------------------------------------------------------------------------
module pwfp_checker
    import pwfp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               result_valid,
    input  wire logic               result_stall,
    input  wire logic [2:0]         result_kind,
    input  wire logic [FID_W-1:0]   field_id,
    input  wire logic [2:0]         wire_kind,
    input  wire logic [WORD_W-1:0]  field_value,
    input  wire logic [7:0]         payload_data,
    input  wire logic               message_done
);

    // a stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_kind) &&
        $stable(field_id) && $stable(field_value) && $stable(payload_data) &&
        $stable(message_done))
        else $error("result item changed while stalled");

    a_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind == KIND_PAYLOAD || result_kind == KIND_BAD_WIRE ||
        result_kind == KIND_TRUNC) |-> field_value == '0)
        else $error("value set on payload or error item");

    a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind != KIND_PAYLOAD |-> payload_data == '0)
        else $error("payload byte set on non-payload item");

    a_trunc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == KIND_TRUNC |-> field_id == '0 && wire_kind == '0)
        else $error("truncation item carries a field");

    a_length_type: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind == KIND_HEADER || result_kind == KIND_PAYLOAD)
        |-> wire_kind == WT_LENGTH)
        else $error("header or payload item without length wire type");

endmodule : pwfp_checker

bind protobuf_wire_field_parser pwfp_checker u_pwfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_kind  (result_kind),
    .field_id     (field_id),
    .wire_kind    (wire_kind),
    .field_value  (field_value),
    .payload_data (payload_data),
    .message_done (message_done)
);
`default_nettype wire

[bench/tb_protobuf_wire_field_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_protobuf_wire_field_parser
// Self-checking bench for the protobuf wire field parser. Whole messages are
// fed a byte at a time and are mostly well formed, with truncated, overlong,
// oversized-length and noise messages mixed in. A scoreboard parses every
// accepted byte the same way and checks each result item field by field.
// ----------------------------------------------------------------------------
module tb_protobuf_wire_field_parser;
    import pwfp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 1300;
    localparam logic [63:0] LEN_MAX = (64'd1 << LENGTH_BITS_DEF) - 64'd1;

    // wire types the block rejects
    localparam logic [2:0] WT_SGROUP = 3'd3;
    localparam logic [2:0] WT_EGROUP = 3'd4;
    localparam logic [2:0] WT_RSVD6  = 3'd6;
    localparam logic [2:0] WT_RSVD7  = 3'd7;

    localparam int SEND_IDLE[4] = '{0, 59, 0, 32};
    localparam int RECV_STALL[4] = '{0, 0, 59, 32};

    typedef struct {
        res_kind_t        kind;
        logic [FID_W-1:0] fid;
        logic [2:0]       wk;
        logic [63:0]      value;
        logic [7:0]       data;
        logic             done;
    } field_result_t;

    class wire_field_checker;
        phase_t           phase;
        logic [63:0]      acc;
        logic [IDX_W-1:0] idx;
        logic [FID_W-1:0] held_fid;
        logic [2:0]       held_wk;
        logic [63:0]      left;
        bit               in_error;
        field_result_t    pending_fields[$];
        int               parsed_bytes;
        int               mismatches;
        int               kind_seen[5];

        function new();
            in_error = 1'b0;
            parsed_bytes = 0;
            mismatches = 0;
            foreach (kind_seen[k])
                kind_seen[k] = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_KEY;
            acc = '0;
            idx = '0;
            held_fid = '0;
            held_wk = '0;
            left = '0;
        endfunction

        function void add_result(res_kind_t kind, logic [FID_W-1:0] fid, logic [2:0] wk,
                                 logic [63:0] value, logic [7:0] data, logic done);
            field_result_t r;
            r.kind = kind;
            r.fid = fid;
            r.wk = wk;
            r.value = value;
            r.data = data;
            r.done = done;
            pending_fields.push_back(r);
        endfunction

        // hold off further bytes until the message ends, unless it ends here
        function void abort(res_kind_t kind, logic [FID_W-1:0] fid, logic [2:0] wk, logic eom);
            restart();
            in_error = !eom;
            add_result(kind, fid, wk, 64'd0, 8'd0, eom);
        endfunction

        function void take_byte(logic [7:0] b, logic eom);
            logic [63:0]      v;
            logic [FID_W-1:0] f;
            logic [2:0]       w;
            int unsigned      sh;
            int unsigned      need;
            if (in_error)
            begin
                if (eom)
                begin
                    in_error = 1'b0;
                    restart();
                end
                return;
            end
            parsed_bytes++;
            case (phase)
                PH_KEY, PH_VARVAL, PH_LENGTH:
                begin
                    sh = 7 * idx;
                    // drop chunks that would land above bit 63
                    if (sh < 64)
                        acc = acc | ({57'd0, b[6:0]} << sh);
                    idx = idx + 1'b1;
                    if (b[7])
                    begin
                        if (idx >= MAX_VARINT_BYTES_DEF || eom)
                            abort(KIND_TRUNC, '0, '0, eom);
                        return;
                    end
                    v = acc;
                    acc = '0;
                    idx = '0;
                    if (phase == PH_KEY)
                    begin
                        f = v[31:3];
                        w = v[2:0];
                        case (w)
                            WT_VARINT:              phase = PH_VARVAL;
                            WT_FIXED64, WT_FIXED32: phase = PH_FIXED;
                            WT_LENGTH:              phase = PH_LENGTH;
                            default:
                            begin
                                abort(KIND_BAD_WIRE, f, w, eom);
                                return;
                            end
                        endcase
                        if (eom)
                            abort(KIND_TRUNC, '0, '0, eom);
                        else
                        begin
                            held_fid = f;
                            held_wk = w;
                        end
                    end
                    else if (phase == PH_VARVAL)
                    begin
                        f = held_fid;
                        restart();
                        add_result(KIND_SCALAR, f, WT_VARINT, v, 8'd0, eom);
                    end
                    else if (v > LEN_MAX)
                        abort(KIND_TRUNC, '0, '0, eom);
                    else if (v == 0)
                    begin
                        f = held_fid;
                        restart();
                        add_result(KIND_HEADER, f, WT_LENGTH, 64'd0, 8'd0, eom);
                    end
                    else if (eom)
                        abort(KIND_TRUNC, '0, '0, eom);
                    else
                    begin
                        left = v;
                        phase = PH_PAYLOAD;
                        add_result(KIND_HEADER, held_fid, WT_LENGTH, v, 8'd0, 1'b0);
                    end
                end
                PH_FIXED:
                begin
                    need = (held_wk == WT_FIXED64) ? 8 : 4;
                    acc = acc | ({56'd0, b} << (8 * idx[2:0]));
                    idx = idx + 1'b1;
                    if (idx >= need)
                    begin
                        f = held_fid;
                        w = held_wk;
                        v = acc;
                        restart();
                        add_result(KIND_SCALAR, f, w, v, 8'd0, eom);
                    end
                    else if (eom)
                        abort(KIND_TRUNC, '0, '0, eom);
                end
                PH_PAYLOAD:
                begin
                    f = held_fid;
                    if (left > 0)
                        left = left - 1;
                    if (left == 0)
                    begin
                        restart();
                        add_result(KIND_PAYLOAD, f, WT_LENGTH, 64'd0, b, eom);
                    end
                    else if (eom)
                        abort(KIND_TRUNC, '0, '0, eom);
                    else
                        add_result(KIND_PAYLOAD, f, WT_LENGTH, 64'd0, b, 1'b0);
                end
                default: restart();
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void match_result(logic [2:0] kind, logic [FID_W-1:0] fid, logic [2:0] wk,
                                   logic [63:0] value, logic [7:0] data, logic done);
            field_result_t want;
            if (pending_fields.size() == 0)
            begin
                $display("%0t: unexpected result item: expected none, actual kind %0d field %0d",
                         $time, kind, fid);
                mismatches++;
                return;
            end
            want = pending_fields.pop_front();
            if (kind < 5)
                kind_seen[kind]++;
            compare_field("result_kind", want.kind, kind);
            compare_field("field_id", want.fid, fid);
            compare_field("wire_kind", want.wk, wk);
            compare_field("field_value", want.value, value);
            compare_field("payload_data", want.data, data);
            compare_field("message_done", want.done, done);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               byte_valid;
    logic               byte_stall;
    logic [7:0]         data_byte;
    logic               end_of_message;
    logic               result_valid;
    logic               result_stall;
    logic [2:0]         result_kind;
    logic [FID_W-1:0]   field_id;
    logic [2:0]         wire_kind;
    logic [WORD_W-1:0]  field_value;
    logic [7:0]         payload_data;
    logic               message_done;

    wire_field_checker  chk;
    logic [7:0]         msg[$];
    int                 send_idle_pct;
    int                 stall_pct;
    int                 hold_cycles;
    int                 cycle_count;
    int                 messages;

    protobuf_wire_field_parser u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result_kind    (result_kind),
        .field_id       (field_id),
        .wire_kind      (wire_kind),
        .field_value    (field_value),
        .payload_data   (payload_data),
        .message_done   (message_done)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
            $display("** protobuf_wire_field_parser: FAILED **");
            $finish;
        end
    end

    // result side: a long hold-off when asked, random stalls otherwise
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            result_stall <= 1'b1;
            hold_cycles--;
        end
        else
            result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                chk.take_byte(data_byte, end_of_message);
            if (result_valid && !result_stall)
                chk.match_result(result_kind, field_id, wire_kind, field_value,
                                 payload_data, message_done);
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 4))
            0:       return 64'd0;
            1:       return '1;
            2:       return {$urandom, $urandom};
            default: return {$urandom, $urandom} >> $urandom_range(1, 63);
        endcase
    endfunction

    function automatic int rand_pad();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // append v as a varint, optionally padded with empty continuation bytes
    function automatic void put_varint(logic [63:0] v, int pad, bit junk);
        logic [63:0] t;
        logic [7:0]  b;
        int          nb;
        nb = 1;
        t = v >> 7;
        while (t != 0)
        begin
            nb++;
            t = t >> 7;
        end
        if (pad > 10 - nb)
            pad = 10 - nb;
        for (int i = 0; i < nb; i++)
        begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (i < nb - 1 || pad > 0)
                b[7] = 1'b1;
            // tenth byte carries bit 63 only; fill the rest with bits that get dropped
            if (i == 9 && junk)
                b[6:1] = 6'($urandom_range(0, 63));
            msg.push_back(b);
        end
        for (int i = 0; i < pad; i++)
            msg.push_back((i == pad - 1) ? 8'h00 : 8'h80);
    endfunction

    function automatic void put_bytes(logic [63:0] v, int n);
        for (int i = 0; i < n; i++)
            msg.push_back(v[8*i +: 8]);
    endfunction

    function automatic void add_field();
        logic [2:0]       wt;
        logic [FID_W-1:0] fid;
        logic [63:0]      key;
        int               r;
        int               len;
        r = $urandom_range(0, 99);
        if (r < 30)
            wt = WT_VARINT;
        else if (r < 45)
            wt = WT_FIXED64;
        else if (r < 60)
            wt = WT_FIXED32;
        else if (r < 94)
            wt = WT_LENGTH;
        else
            case ($urandom_range(0, 3))
                0:       wt = WT_SGROUP;
                1:       wt = WT_EGROUP;
                2:       wt = WT_RSVD6;
                default: wt = WT_RSVD7;
            endcase
        case ($urandom_range(0, 9))
            0:       fid = '1;
            1:       fid = FID_W'($urandom);
            2, 3:    fid = FID_W'($urandom_range(16, 2047));
            default: fid = FID_W'($urandom_range(1, 15));
        endcase
        key = {32'd0, fid, wt};
        // bits above the field number are dropped by the block
        if ($urandom_range(0, 19) == 0)
            key[63:32] = $urandom;
        put_varint(key, rand_pad(), 1'b1);
        case (wt)
            WT_VARINT:  put_varint(rand_word(), rand_pad(), 1'b1);
            WT_FIXED64: put_bytes(rand_word(), 8);
            WT_FIXED32: put_bytes(rand_word(), 4);
            WT_LENGTH:
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
                put_varint(64'(len), rand_pad(), 1'b0);
                repeat (len)
                    msg.push_back(8'($urandom));
            end
            default: ;
        endcase
    endfunction

    function automatic void build_message();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            repeat ($urandom_range(1, 4))
                add_field();
            // cut short by at least one byte, so the end may land inside a field
            if (r >= 70 && msg.size() > 1)
                msg = msg[0:$urandom_range(0, msg.size() - 2)];
        end
        else if (r < 87)
        begin
            if ($urandom_range(0, 1))
                put_varint({32'd0, FID_W'($urandom_range(1, 15)), WT_VARINT}, 0, 1'b0);
            repeat ($urandom_range(10, 12))
                msg.push_back(8'h80 | 8'($urandom_range(0, 127)));
            repeat ($urandom_range(0, 3))
                msg.push_back(8'($urandom));
        end
        else if (r < 94)
        begin
            put_varint({32'd0, FID_W'($urandom_range(1, 15)), WT_LENGTH}, 0, 1'b0);
            put_varint(rand_word() | (64'd1 << $urandom_range(LENGTH_BITS_DEF, 63)), 0, 1'b1);
            repeat ($urandom_range(0, 3))
                msg.push_back(8'($urandom));
        end
        else
            repeat ($urandom_range(1, 8))
                msg.push_back(8'($urandom));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eom);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte <= b;
        end_of_message <= eom;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
    endtask

    task automatic send_msg();
        for (int i = 0; i < msg.size(); i++)
            send_byte(msg[i], i == msg.size() - 1);
        msg.delete();
        messages++;
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (chk.pending_fields.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int base;
        chk = new();
        clk = 1'b0;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        data_byte = 8'd0;
        end_of_message = 1'b0;
        result_stall = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        cycle_count = 0;
        messages = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // varint zero, all-ones fixed32, empty bytes field
        msg = '{8'h08, 8'h00};
        send_msg();
        msg = '{8'h0D, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_msg();
        msg = '{8'h12, 8'h00};
        send_msg();
        // bad wire type on the last byte, then one mid-message that drops the rest
        msg = '{8'h1B};
        send_msg();
        msg = '{8'h0F, 8'h55, 8'h66};
        send_msg();
        // message ends inside a payload
        msg = '{8'h12, 8'h02, 8'hAA};
        send_msg();
        // ten-byte varint with bits beyond bit 63
        msg = '{8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        send_msg();
        drain();

        // hold the result side while bytes keep coming, so the queue backs up
        hold_cycles = 300;
        put_varint({32'd0, 29'd1, WT_LENGTH}, 0, 1'b0);
        put_varint(64'd40, 0, 1'b0);
        repeat (40)
            msg.push_back(8'($urandom));
        send_msg();
        drain();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = SEND_IDLE[p];
            stall_pct = RECV_STALL[p];
            base = chk.parsed_bytes;
            while (chk.parsed_bytes - base < RANDOM_BYTES / 4)
            begin
                build_message();
                send_msg();
            end
            drain();
        end
        stall_pct = 0;
        repeat (8) @(posedge clk);

        $display("Sent %0d messages (%0d bytes parsed) under four idle/stall mixes and a long hold.",
                 messages, chk.parsed_bytes);
        $display("Checked %0d scalars, %0d headers, %0d payload bytes, %0d bad wire, %0d truncated.",
                 chk.kind_seen[KIND_SCALAR], chk.kind_seen[KIND_HEADER],
                 chk.kind_seen[KIND_PAYLOAD], chk.kind_seen[KIND_BAD_WIRE],
                 chk.kind_seen[KIND_TRUNC]);
        if (chk.mismatches == 0 && chk.pending_fields.size() == 0)
            $display("** protobuf_wire_field_parser: PASSED **");
        else
            $display("** protobuf_wire_field_parser: FAILED **");
        $finish;
    end

endmodule
